// File: hw/rtl/lowest_common_ancestor_query_macros.svh
// Assertion macros for the LCA query block.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef LOWEST_COMMON_ANCESTOR_QUERY_MACROS_SVH
`define LOWEST_COMMON_ANCESTOR_QUERY_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LCAQ_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LCAQ_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lcaq_pkg.sv
package lcaq_pkg;

  localparam int FIELD_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_QUERY = 2'd2
  } lcaq_action_t;

  typedef struct packed {
    lcaq_action_t         action;
    logic [FIELD_W-1:0]   node;
    logic [FIELD_W-1:0]   parent_node;
    logic [FIELD_W-1:0]   node_level;
    logic [FIELD_W-1:0]   second_node;
  } lcaq_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0]   ancestor;
    logic                 build_done;
  } lcaq_rsp_t;

  // v mod m for a 10-bit v and an elaboration-time m, as a restoring
  // subtract chain; folds to a plain mask for powers of two.
  function automatic logic [FIELD_W-1:0] wrap_node(logic [FIELD_W-1:0] v,
                                                   int unsigned m);
    logic [19:0] r;
    logic [19:0] s;
    r = {10'd0, v};
    for (int i = FIELD_W - 1; i >= 0; i--) begin
      s = 20'(m) << i;
      if (m < 1024 && s <= r) begin
        r = r - s;
      end
    end
    return r[FIELD_W-1:0];
  endfunction

endpackage

// File: hw/rtl/lcaq_core.sv
module lcaq_core #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lcaq_pkg::COUNT_W-1:0]     node_count,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  lcaq_pkg::lcaq_req_t              req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output lcaq_pkg::lcaq_rsp_t              rsp
);
  import lcaq_pkg::*;

  // Only node indexes below 1024 can ever be addressed.
  localparam int NODE_SPAN  = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam int IDX_W      = $clog2(NODE_SPAN);
  localparam int NODE_SLOTS = 1 << IDX_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int LVL_W      = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam logic [LVL_W-1:0]   LAST_LVL = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [COUNT_W-1:0] SPAN_CNT = COUNT_W'(NODE_SPAN);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_BUILD,
    ST_Q_DEPTH,
    ST_Q_ORDER,
    ST_Q_LIFT,
    ST_Q_MATCH,
    ST_Q_RAISE,
    ST_Q_LAST,
    ST_DONE
  } state_t;

  // ancestor table: level k holds the 2^k-th ancestor; depth store
  logic [IDX_W-1:0]   tbl [LIFT_LEVELS][NODE_SLOTS];
  logic [FIELD_W-1:0] dep [NODE_SLOTS];

  state_t             state;
  logic [IDX_W-1:0]   a;
  logic [IDX_W-1:0]   b;
  logic [IDX_W-1:0]   parent;
  logic [FIELD_W-1:0] level;
  logic [FIELD_W-1:0] diff;
  logic               pend;
  logic [LVL_W-1:0]   lvl;
  logic [CNT_W-1:0]   bcnt;
  logic [CNT_W-1:0]   bj;
  logic               p1_vld;
  logic               p2_vld;
  logic [IDX_W-1:0]   p1_idx;
  logic [IDX_W-1:0]   p2_idx;

  logic [IDX_W-1:0]   rd0_data;
  logic [IDX_W-1:0]   rd1_data;
  logic [FIELD_W-1:0] dep_rd0;
  logic [FIELD_W-1:0] dep_rd1;

  logic [LVL_W-1:0]   rd0_lvl;
  logic [LVL_W-1:0]   rd1_lvl;
  logic [IDX_W-1:0]   rd0_idx;
  logic [IDX_W-1:0]   rd1_idx;
  logic               wr_en;
  logic [LVL_W-1:0]   wr_lvl;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   wr_data;

  logic [FIELD_W-1:0] node_wr;
  logic [FIELD_W-1:0] second_wr;
  logic [FIELD_W-1:0] parent_wr;
  logic [COUNT_W-1:0] cnt_cap;
  logic [IDX_W-1:0]   a_eff;
  logic [IDX_W-1:0]   a_up;
  logic [IDX_W-1:0]   b_up;
  logic [LVL_W-1:0]   lvl_dn;

  assign node_wr   = wrap_node(req.node, MAX_NODES);
  assign second_wr = wrap_node(req.second_node, MAX_NODES);
  assign parent_wr = wrap_node(req.parent_node, MAX_NODES);
  assign cnt_cap   = (node_count > SPAN_CNT) ? SPAN_CNT : node_count;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);

  // lift result of the previous level, if that bit was set
  assign a_eff  = pend ? rd0_data : a;
  // raise both nodes only while their ancestors differ
  assign a_up   = (rd0_data != rd1_data) ? rd0_data : a;
  assign b_up   = (rd0_data != rd1_data) ? rd1_data : b;
  assign lvl_dn = (lvl == '0) ? lvl : lvl - LVL_W'(1);

  always_comb begin
    rd0_lvl = lvl;
    rd0_idx = a;
    rd1_lvl = lvl;
    rd1_idx = b;
    wr_en   = 1'b0;
    wr_lvl  = lvl;
    wr_idx  = p2_idx;
    wr_data = rd1_data;
    unique case (state)
      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_lvl  = '0;
        wr_idx  = a;
        wr_data = parent;
      end
      ST_BUILD: begin
        // two chained reads of level k-1, write to level k
        rd0_lvl = lvl - LVL_W'(1);
        rd0_idx = bj[IDX_W-1:0];
        rd1_lvl = lvl - LVL_W'(1);
        rd1_idx = rd0_data;
        wr_en   = p2_vld;
      end
      ST_Q_LIFT: begin
        rd0_idx = a_eff;
      end
      ST_Q_MATCH: begin
        rd0_lvl = LAST_LVL;
        rd0_idx = a_eff;
        rd1_lvl = LAST_LVL;
      end
      ST_Q_RAISE: begin
        rd0_lvl = lvl_dn;
        rd0_idx = a_up;
        rd1_lvl = lvl_dn;
        rd1_idx = b_up;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_lvl][wr_idx] <= wr_data;
    end
    rd0_data <= tbl[rd0_lvl][rd0_idx];
    rd1_data <= tbl[rd1_lvl][rd1_idx];
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      dep[a] <= level;
    end
    dep_rd0 <= dep[a];
    dep_rd1 <= dep[b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            a      <= node_wr[IDX_W-1:0];
            b      <= second_wr[IDX_W-1:0];
            parent <= parent_wr[IDX_W-1:0];
            level  <= req.node_level;
            bcnt   <= cnt_cap[CNT_W-1:0];
            bj     <= '0;
            p1_vld <= 1'b0;
            p2_vld <= 1'b0;
            priority case (req.action)
              ACT_WRITE: state <= ST_WRITE;
              ACT_BUILD: begin
                rsp.ancestor   <= '0;
                rsp.build_done <= 1'b1;
                if (LIFT_LEVELS == 1) begin
                  state <= ST_DONE;
                end else begin
                  lvl   <= LVL_W'(1);
                  state <= ST_BUILD;
                end
              end
              ACT_QUERY: state <= ST_Q_DEPTH;
              default:   state <= ST_IDLE;
            endcase
          end
        end
        ST_WRITE: begin
          state <= ST_IDLE;
        end
        ST_BUILD: begin
          p2_vld <= p1_vld;
          p2_idx <= p1_idx;
          if (bj < bcnt) begin
            p1_vld <= 1'b1;
            p1_idx <= bj[IDX_W-1:0];
            bj     <= bj + CNT_W'(1);
          end else begin
            p1_vld <= 1'b0;
            // level finished once the pipe has drained
            if (!p1_vld && !p2_vld) begin
              if (lvl == LAST_LVL) begin
                state <= ST_DONE;
              end else begin
                lvl <= lvl + LVL_W'(1);
                bj  <= '0;
              end
            end
          end
        end
        ST_Q_DEPTH: begin
          state <= ST_Q_ORDER;
        end
        ST_Q_ORDER: begin
          if (dep_rd0 < dep_rd1) begin
            a    <= b;
            b    <= a;
            diff <= dep_rd1 - dep_rd0;
          end else begin
            diff <= dep_rd0 - dep_rd1;
          end
          pend  <= 1'b0;
          lvl   <= '0;
          state <= ST_Q_LIFT;
        end
        ST_Q_LIFT: begin
          a    <= a_eff;
          pend <= diff[0];
          diff <= diff >> 1;
          if (lvl == LAST_LVL) begin
            state <= ST_Q_MATCH;
          end else begin
            lvl <= lvl + LVL_W'(1);
          end
        end
        ST_Q_MATCH: begin
          a <= a_eff;
          if (a_eff == b) begin
            rsp.ancestor   <= FIELD_W'(a_eff);
            rsp.build_done <= 1'b0;
            state          <= ST_DONE;
          end else begin
            lvl   <= LAST_LVL;
            state <= ST_Q_RAISE;
          end
        end
        ST_Q_RAISE: begin
          a <= a_up;
          b <= b_up;
          if (lvl == '0) begin
            state <= ST_Q_LAST;
          end else begin
            lvl <= lvl_dn;
          end
        end
        ST_Q_LAST: begin
          rsp.ancestor   <= FIELD_W'(rd0_data);
          rsp.build_done <= 1'b0;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/lowest_common_ancestor_query.sv
// Channel  Dir  Handshake               Payload
// cfg      in   cfg_valid / cfg_ready   cfg_data: node_count (11 bits)
// s_*      in   s_tvalid / s_tready     s_tdata: node, parent_node, node_level,
//                                       second_node; s_tuser: action
// m_*      out  m_tvalid / m_tready     m_tdata: ancestor; m_tuser: build_done
//
// A query steps one level at a time through the dual-read ancestor table, once
// lifting, once raising; a build runs level by level, one table entry per cycle.
// Reset clears control and sets node_count to 1024; table and depth store are
// undefined until written, no clearing pass.
// Requests are taken one at a time; a finished result sits in the output
// register so the next request can start while m_tready is low.
module lowest_common_ancestor_query #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcaq_pkg::COUNT_W-1:0]        cfg_data,    // node_count
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [9:0] node, [19:10] parent_node, [29:20] node_level, [39:30] second_node
  input  logic [lcaq_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [1:0]                          s_tuser,     // [1:0] action
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lcaq_pkg::OUT_DATA_W-1:0]     m_tdata,     // [9:0] ancestor
  output logic [0:0]                          m_tuser      // [0] build_done
);
  import lcaq_pkg::*;

  logic [COUNT_W-1:0] node_count;
  lcaq_req_t          req;
  lcaq_rsp_t          rsp;
  logic               rsp_valid;
  logic               rsp_ready;

  // config must only be written while idle (the block does not enforce this), so it is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      node_count <= cfg_data;
    end
  end

  assign req.action      = lcaq_action_t'(s_tuser);
  assign req.node        = s_tdata[9:0];
  assign req.parent_node = s_tdata[19:10];
  assign req.node_level  = s_tdata[29:20];
  assign req.second_node = s_tdata[39:30];

  lcaq_core #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .node_count (node_count),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

  // output register: core hands over when the slot is empty or draining
  assign rsp_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_DATA_W'(rsp.ancestor);
      m_tuser  <= rsp.build_done;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// File: hw/rtl/lcaq_checker.sv
`include "lowest_common_ancestor_query_macros.svh"

module lcaq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [lcaq_pkg::COUNT_W-1:0]        cfg_data,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [lcaq_pkg::IN_DATA_W-1:0]      s_tdata,
  input logic [1:0]                          s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [lcaq_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [0:0]                          m_tuser
);
  import lcaq_pkg::*;

  // stalled result holds
  `LCAQ_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // a build answer carries a zero ancestor
  `LCAQ_CHECK_NOW(a_build_zero, m_tvalid && m_tuser[0],
    m_tdata == '0, "build answer with nonzero ancestor")

  // no result can appear in the cycle right after a request is taken
  `LCAQ_CHECK_NEXT(a_no_instant, s_tvalid && s_tready,
    !$rose(m_tvalid), "result too soon after request")

endmodule

bind lowest_common_ancestor_query lcaq_checker u_lcaq_checker (.*);
